/* sv/bst_pkg.sv */
// ---------------------------------------------------------------------------
// bst_pkg
// Shared constants and types of the bidirectional session table.
// ---------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

  localparam int unsigned SESSIONS = 64;
  localparam int unsigned IDX_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int unsigned CNT_W    = $clog2(SESSIONS + 1);
  localparam int unsigned OIDX_W   = 6;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } tuple_t;

  localparam int unsigned TUPLE_W = $bits(tuple_t);

  typedef struct packed {
    logic              accepted;
    logic [OIDX_W-1:0] session_index;
    logic              new_session;
    logic              reversed;
    logic              table_full;
  } result_t;

  // Control bundle from the scan controller to the session memory.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    tuple_t           wr_data;
  } ram_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

/* sv/bst_req_if.sv */
// ---------------------------------------------------------------------------
// bst_req_if
// Packet request channel: valid/ready handshake with the packet tuple.
// ---------------------------------------------------------------------------
`default_nettype none

interface bst_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  ip_protocol;

  modport source (
    output valid, src_addr, dst_addr, src_port, dst_port, ip_protocol,
    input  ready
  );

  modport sink (
    input  valid, src_addr, dst_addr, src_port, dst_port, ip_protocol,
    output ready
  );
endinterface

`default_nettype wire

/* sv/bst_rsp_if.sv */
// ---------------------------------------------------------------------------
// bst_rsp_if
// Result channel: valid/ready handshake with the session lookup result.
// ---------------------------------------------------------------------------
`default_nettype none

interface bst_rsp_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [5:0] session_index;
  logic       new_session;
  logic       reversed;
  logic       table_full;

  modport source (
    output valid, accepted, session_index, new_session, reversed, table_full,
    input  ready
  );

  modport sink (
    input  valid, accepted, session_index, new_session, reversed, table_full,
    output ready
  );
endinterface

`default_nettype wire

/* sv/bst_ram.sv */
// ---------------------------------------------------------------------------
// bst_ram
// Simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module bst_ram #(
  parameter  int unsigned DEPTH = 64,
  parameter  int unsigned WIDTH = 96,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/bst_ctrl.sv */
// ---------------------------------------------------------------------------
// bst_ctrl
// Scan controller: walks stored sessions, matches both ways, appends new.
// ---------------------------------------------------------------------------
`default_nettype none

module bst_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  bst_req_if.sink                req_i,
  bst_rsp_if.source              rsp_o,
  output bst_pkg::ram_req_t      ram_req_o,
  input  wire bst_pkg::tuple_t   ram_rdata_i
);

  import bst_pkg::*;

  state_e           state_q, state_d;
  tuple_t           key_q, key_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  result_t          res_q, res_d;
  logic             ins_q, ins_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_res_q, out_res_d;

  logic direct;
  logic swapped;
  logic last;
  logic out_free;
  logic proto_ok;

  assign direct  = (ram_rdata_i == key_q);
  assign swapped = (ram_rdata_i.src_addr == key_q.dst_addr) &&
                   (ram_rdata_i.dst_addr == key_q.src_addr) &&
                   (ram_rdata_i.src_port == key_q.dst_port) &&
                   (ram_rdata_i.dst_port == key_q.src_port);
  assign last     = (CNT_W'(idx_q + CNT_W'(1)) == count_q);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign proto_ok = (req_i.ip_protocol == PROTO_TCP) ||
                    (req_i.ip_protocol == PROTO_UDP);

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    idx_d       = idx_q;
    count_d     = count_q;
    res_d       = res_q;
    ins_d       = ins_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_res_d   = out_res_q;

    ram_req_o         = '0;
    ram_req_o.rd_addr = IDX_W'(idx_q + CNT_W'(1));
    ram_req_o.wr_addr = IDX_W'(count_q);
    ram_req_o.wr_data = key_q;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          key_d.src_addr = req_i.src_addr;
          key_d.dst_addr = req_i.dst_addr;
          key_d.src_port = req_i.src_port;
          key_d.dst_port = req_i.dst_port;
          idx_d          = '0;
          res_d          = '0;
          ins_d          = 1'b0;
          if (!proto_ok) begin
            state_d = ST_DONE;
          end else if (count_q == '0) begin
            // empty table: append at entry 0
            res_d.accepted    = 1'b1;
            res_d.new_session = 1'b1;
            ins_d             = 1'b1;
            state_d           = ST_DONE;
          end else begin
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = '0;
            state_d           = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (direct || swapped) begin
          res_d.accepted      = 1'b1;
          res_d.session_index = OIDX_W'(idx_q);
          res_d.reversed      = !direct;
          state_d             = ST_DONE;
        end else if (last) begin
          if (count_q == CNT_W'(SESSIONS)) begin
            res_d.table_full = 1'b1;
          end else begin
            res_d.accepted      = 1'b1;
            res_d.new_session   = 1'b1;
            res_d.session_index = OIDX_W'(count_q);
            ins_d               = 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          idx_d           = CNT_W'(idx_q + CNT_W'(1));
          ram_req_o.rd_en = 1'b1;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          if (ins_q) begin
            ram_req_o.wr_en = 1'b1;
            count_d         = CNT_W'(count_q + CNT_W'(1));
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    idx_q     <= idx_d;
    res_q     <= res_d;
    ins_q     <= ins_d;
    out_res_q <= out_res_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.accepted      = out_res_q.accepted;
  assign rsp_o.session_index = out_res_q.session_index;
  assign rsp_o.new_session   = out_res_q.new_session;
  assign rsp_o.reversed      = out_res_q.reversed;
  assign rsp_o.table_full    = out_res_q.table_full;

endmodule

`default_nettype wire

/* sv/bidirectional_session_table_core.sv */
// ---------------------------------------------------------------------------
// bidirectional_session_table_core
// Tracks TCP/UDP sessions by address/port tuple, matching either direction.
// ---------------------------------------------------------------------------
// One packet request is taken at a time. A TCP or UDP packet checked against
// the stored sessions moves through ST_IDLE, ST_SCAN and ST_DONE. Acceptance
// issues the first memory read. Then comes one compare cycle per stored
// session: the session memory has a single read port, so one entry is
// examined per cycle. In ST_DONE, once the output register is free, the result
// is registered and, on a miss with room, a new entry is appended. Other
// protocols and an empty table skip the scan and go from acceptance
// straight to ST_DONE. With the table full a miss compares all SESSIONS = 64
// stored entries. The result sits in an output register, so the next request
// is taken while it waits to be read. If the next result is ready first, it
// waits in ST_DONE until the output register is free. No clearing pass is
// needed after reset: only entries below the session count are ever read.
`default_nettype none

module bidirectional_session_table_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bst_req_if.sink   req_i,
  bst_rsp_if.source rsp_o
);

  import bst_pkg::*;

  ram_req_t ram_req;   // read/write controls from the scan controller
  tuple_t   ram_rdata; // stored tuple, registered by the read

  // Scan controller: FSM, two-way tuple compare, session count, result reg.
  bst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  // Session store: one tuple per entry, written only on append.
  bst_ram #(
    .DEPTH (SESSIONS),
    .WIDTH (TUPLE_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (ram_rdata),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data)
  );

endmodule

`default_nettype wire

/* sim/bst_session_checker.sv */
// ---------------------------------------------------------------------------
// bst_session_checker
// Watches both channels of the session table, keeps its own copy of the
// session store and checks every result against the expected lookup.
// ---------------------------------------------------------------------------
`default_nettype none

module bst_session_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  bst_req_if                req_i,
  bst_rsp_if                rsp_i,
  output int unsigned       pending_o,
  output int unsigned       error_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import bst_pkg::*;

  tuple_t      session_store [SESSIONS];
  int unsigned session_total;
  result_t     lookup_q [$];
  int unsigned mismatches;

  assign error_count_o = mismatches;

  // Lookup as the table performs it: first hit in creation order, direct
  // before swapped, TCP/UDP alike, others rejected; append on a miss if room remains.
  function automatic result_t track_packet(tuple_t pkt, logic [7:0] proto);
    result_t res;
    tuple_t  swapped;
    bit      found;
    res = '0;
    found = 1'b0;
    swapped.src_addr = pkt.dst_addr;
    swapped.dst_addr = pkt.src_addr;
    swapped.src_port = pkt.dst_port;
    swapped.dst_port = pkt.src_port;
    if (proto != PROTO_TCP && proto != PROTO_UDP) begin
      return res;
    end
    for (int unsigned i = 0; i < session_total && !found; i++) begin
      if (session_store[i] == pkt || session_store[i] == swapped) begin
        found = 1'b1;
        res.accepted = 1'b1;
        res.session_index = OIDX_W'(i);
        res.reversed = (session_store[i] != pkt);
      end
    end
    if (found) begin
      return res;
    end
    if (session_total >= SESSIONS) begin
      res.table_full = 1'b1;
      return res;
    end
    session_store[session_total] = pkt;
    res.accepted = 1'b1;
    res.session_index = OIDX_W'(session_total);
    res.new_session = 1'b1;
    session_total++;
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tuple_t  pkt;
    result_t want;
    if (!rst_ni) begin
      session_total = 0;
      mismatches = 0;
      lookup_q.delete();
      pending_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        pkt.src_addr = req_i.src_addr;
        pkt.dst_addr = req_i.dst_addr;
        pkt.src_port = req_i.src_port;
        pkt.dst_port = req_i.dst_port;
        lookup_q.push_back(track_packet(pkt, req_i.ip_protocol));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (lookup_q.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = lookup_q.pop_front();
          check_field("accepted", 32'(want.accepted), 32'(rsp_i.accepted));
          check_field("session_index", 32'(want.session_index),
                      32'(rsp_i.session_index));
          check_field("new_session", 32'(want.new_session), 32'(rsp_i.new_session));
          check_field("reversed", 32'(want.reversed), 32'(rsp_i.reversed));
          check_field("table_full", 32'(want.table_full), 32'(rsp_i.table_full));
        end
      end
      pending_o <= lookup_q.size();
    end
  end

endmodule

`default_nettype wire

/* sim/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the bidirectional session table.
// ---------------------------------------------------------------------------
// A short directed run covers ignored protocols, the all-zero and all-ones
// tuples, tuples equal to their own swap, reversed hits across protocols and
// near misses. The random run then fills the table and keeps hammering it
// once full, with both channels throttled at random. Checking lives in
// bst_session_checker.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bst_pkg::*;

  localparam int unsigned TRACKED_REQS = 500;
  // Worst quiet spell is roughly a long sender gap + a full-table scan + a
  // long result stall; this allows ample margin on top.
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 70;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned error_count;
  bit          sender_calm;
  tuple_t      seen_tuples [$];

  bst_req_if req_if ();
  bst_rsp_if rsp_if ();

  bidirectional_session_table_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bst_session_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .pending_o     (pending),
    .error_count_o (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Idle spell length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(bit calm, int unsigned long_max);
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, long_max);
  endfunction

  function automatic logic [31:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_port();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic tuple_t fresh_tuple();
    tuple_t t;
    t.src_addr = pick_addr();
    t.dst_addr = pick_addr();
    t.src_port = pick_port();
    t.dst_port = pick_port();
    return t;
  endfunction

  function automatic tuple_t swap_ends(tuple_t t);
    tuple_t s;
    s.src_addr = t.dst_addr;
    s.dst_addr = t.src_addr;
    s.src_port = t.dst_port;
    s.dst_port = t.src_port;
    return s;
  endfunction

  function automatic logic [7:0] tracked_proto();
    return ($urandom_range(0, 1) != 0) ? PROTO_TCP : PROTO_UDP;
  endfunction

  function automatic logic [7:0] other_proto();
    logic [7:0] p;
    do begin
      p = 8'($urandom_range(0, 255));
    end while (p == PROTO_TCP || p == PROTO_UDP);
    return p;
  endfunction

  // Presents one request after a random gap and returns in the time step of
  // its handshake, so a following request can go out back to back.
  task automatic send_packet(tuple_t pkt, logic [7:0] proto);
    int unsigned gap;
    gap = pick_gap(sender_calm, 40);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.src_addr    <= pkt.src_addr;
    req_if.dst_addr    <= pkt.dst_addr;
    req_if.src_port    <= pkt.src_port;
    req_if.dst_port    <= pkt.dst_port;
    req_if.ip_protocol <= proto;
    do @(posedge clk_i); while (!req_if.ready);
    if (proto == PROTO_TCP || proto == PROTO_UDP) begin
      seen_tuples.push_back(pkt);
    end
  endtask

  // Holds off the sender until every outstanding request has its result.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Result side: random stalls, with calm stretches where ready stays high.
  initial begin
    int unsigned stall;
    int unsigned span;
    bit          calm;
    stall = 0;
    span  = 0;
    calm  = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        span = $urandom_range(50, 400);
      end
      span--;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
        stall = pick_gap(calm, 50);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tuple_t      pkt;
    tuple_t      sym;
    tuple_t      flow;
    int unsigned tracked;
    int unsigned kind;
    int unsigned step;

    sender_calm = 1'b0;
    rst_ni <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.src_addr    <= '0;
    req_if.dst_addr    <= '0;
    req_if.src_port    <= '0;
    req_if.dst_port    <= '0;
    req_if.ip_protocol <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---------------------------------------------------------
    // Ignored protocols: the extremes and the neighbours of TCP and UDP.
    send_packet('0, 8'd0);
    send_packet('1, 8'd255);
    send_packet('0, PROTO_TCP - 8'd1);
    send_packet('0, PROTO_TCP + 8'd1);
    send_packet('1, PROTO_UDP - 8'd1);
    send_packet('1, PROTO_UDP + 8'd1);

    // All-zero and all-ones tuples are their own swap: hits must be direct.
    send_packet('0, PROTO_TCP);
    send_packet('1, PROTO_UDP);
    send_packet('0, PROTO_UDP);
    send_packet('1, PROTO_TCP);

    sym.src_addr = 32'h0A00_0001;
    sym.dst_addr = 32'h0A00_0001;
    sym.src_port = 16'd80;
    sym.dst_port = 16'd80;
    send_packet(sym, PROTO_TCP);
    send_packet(sym, PROTO_UDP);

    // A real flow, then its reply on the other protocol: reversed hit.
    flow.src_addr = 32'hC0A8_0001;
    flow.dst_addr = 32'h0808_0808;
    flow.src_port = 16'd1234;
    flow.dst_port = 16'd53;
    send_packet(flow, PROTO_UDP);
    send_packet(swap_ends(flow), PROTO_TCP);
    send_packet(flow, PROTO_UDP);

    // Near misses: addresses swapped but not ports, and a single port bit off.
    pkt = flow;
    pkt.src_addr = flow.dst_addr;
    pkt.dst_addr = flow.src_addr;
    send_packet(pkt, PROTO_TCP);
    pkt = flow;
    pkt.dst_port = flow.dst_port ^ 16'h8000;
    send_packet(pkt, PROTO_UDP);
    send_packet(flow, other_proto());

    drain_results();

    // --- random -----------------------------------------------------------
    // Mostly replays of known tuples (either direction) with fresh flows in
    // between, so the table fills early and the rest runs against a full one.
    tracked = 0;
    step = 0;
    while (tracked < TRACKED_REQS) begin
      if (step % 64 == 0) begin
        sender_calm = ($urandom_range(0, 3) == 0);
      end
      if (step == 150) begin
        drain_results();
      end
      step++;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        pkt = (seen_tuples.size() != 0 && kind < 4) ?
              seen_tuples[$urandom_range(0, seen_tuples.size() - 1)] : fresh_tuple();
        send_packet(pkt, other_proto());
      end else begin
        if (kind < 45) begin
          pkt = seen_tuples[$urandom_range(0, seen_tuples.size() - 1)];
        end else if (kind < 70) begin
          pkt = swap_ends(seen_tuples[$urandom_range(0, seen_tuples.size() - 1)]);
        end else if (kind < 76) begin
          pkt = fresh_tuple();
          pkt.dst_addr = pkt.src_addr;
          pkt.dst_port = pkt.src_port;
        end else if (kind < 84) begin
          // one bit away from a known session
          pkt = seen_tuples[$urandom_range(0, seen_tuples.size() - 1)];
          pkt[$urandom_range(0, TUPLE_W - 1)] ^= 1'b1;
        end else begin
          pkt = fresh_tuple();
        end
        send_packet(pkt, tracked_proto());
        tracked++;
      end
    end

    // --- wind down --------------------------------------------------------
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
